FILE: design/b2i_pkg.sv
package b2i_pkg;

    // Register file
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH = 13'd1920;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 13'd1080;

    // BT.601 studio-range coefficients
    localparam int Y_R = 66;
    localparam int Y_G = 129;
    localparam int Y_B = 25;
    localparam int U_R = 38;
    localparam int U_G = 74;
    localparam int U_B = 112;
    localparam int V_R = 112;
    localparam int V_G = 94;
    localparam int V_B = 18;
    localparam int ROUND_OFS = 128;
    localparam int LUMA_OFS = 16;
    // rounding term plus 128 * 256 chroma bias, keeps the sum non-negative
    localparam int CHROMA_OFS = 32896;

    localparam int SUM_W = 17;
    localparam int PAIR_W = 9;
    localparam int ENTRY_W = 2 * PAIR_W;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] luma;
        logic       chroma_valid;
        logic [7:0] u_sample;
        logic [7:0] v_sample;
        logic       frame_end;
    } t_pix_out;

    // Position of one pixel inside the frame
    typedef struct packed {
        logic odd_col;
        logic last_col;
        logic odd_row;
        logic last_row;
        logic frame_end;
    } t_pos;

    typedef struct packed {
        logic       valid;
        logic [7:0] u;
        logic [7:0] v;
    } t_chroma;

endpackage

FILE: design/bgra_to_i420_converter_unit.sv
// Pixel-stream RGB to YUV 4:2:0 converter, BT.601 studio range.
// Input channel: i_valid / o_stall carry one pixel (blue, green, red) per item
// in raster order. Output channel: o_valid / i_stall carry one result item per
// pixel: luma, a chroma pair flagged by chroma_valid on the pixel that closes a
// 2x2 block, and frame_end on the last pixel of the frame.
// Configuration: i_cfg_valid / o_cfg_ready write frame_width (index 0) or
// frame_height (index 1); o_cfg_ready is always high. Any such write restarts
// the frame. Write only while no item is in flight.
// o_valid rises once an accepted item has passed the input, converted-sample
// and output stage registers; one item per cycle is accepted as long as
// the output is taken. The line store is a single memory with one write and
// one registered read port per cycle, holding the pair sums of even rows
// until the odd row below reads them.
// Reset restores 1920 x 1080, clears position and pipeline; the line store is
// not cleared and needs no clearing pass. When the receiver stalls, the three
// stage registers fill and o_stall rises; the held output item does not change.
module bgra_to_i420_converter_unit #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  b2i_pkg::t_pix_in                  i_pixel,
    output logic                              o_valid,
    input  logic                              i_stall,
    output b2i_pkg::t_pix_out                 o_pixel,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [b2i_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [b2i_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import b2i_pkg::*;

    localparam int XW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam logic [CFG_DATA_W:0] MAX_W_L = (CFG_DATA_W+1)'(MAX_WIDTH);
    localparam logic [CFG_DATA_W:0] MAX_H_L = (CFG_DATA_W+1)'(MAX_HEIGHT);

    logic [CFG_DATA_W-1:0] r_width;
    logic [CFG_DATA_W-1:0] r_height;
    logic [XW-1:0]         r_x;
    logic [YW-1:0]         r_y;
    logic [XW-1:0]         w_m1;
    logic [YW-1:0]         h_m1;
    logic                  cfg_we;
    logic                  restart;
    logic                  acc;
    t_pos                  pos;

    logic                  r_v1;
    t_pix_in               r_s1_pix;
    t_pos                  r_s1_pos;
    logic [AW-1:0]         r_s1_slot;

    logic                  r_v2;
    logic [7:0]            r_s2_luma;
    logic [7:0]            r_s2_u;
    logic [7:0]            r_s2_v;
    t_pos                  r_s2_pos;
    logic [AW-1:0]         r_s2_slot;

    logic                  r_v3;
    t_pix_out              r_out;

    logic [PAIR_W-1:0]     r_pair_u;
    logic [PAIR_W-1:0]     r_pair_v;
    logic [PAIR_W-1:0]     n_pair_u;
    logic [PAIR_W-1:0]     n_pair_v;

    logic                  rdy1;
    logic                  rdy2;
    logic                  rdy3;
    logic                  mv1;
    logic                  mv2;
    logic [7:0]            csc_luma;
    logic [7:0]            csc_u;
    logic [7:0]            csc_v;
    logic [ENTRY_W-1:0]    line_rd;
    logic                  line_we_raw;
    logic                  line_we;
    logic [ENTRY_W-1:0]    line_wd;
    t_chroma               chroma;

    // Configuration writes
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        restart = 1'b0;
        if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  restart = 1'b1;
                CFG_FRAME_HEIGHT: restart = 1'b1;
                default:          restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_FRAME_WIDTH;
            r_height <= RST_FRAME_HEIGHT;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_width <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Clamp frame size to 1..MAX and form the last index
    always_comb begin
        if (r_width == '0) begin
            w_m1 = '0;
        end else if ({1'b0, r_width} >= MAX_W_L) begin
            w_m1 = XW'(MAX_WIDTH - 1);
        end else begin
            w_m1 = XW'(r_width - 1'b1);
        end
        if (r_height == '0) begin
            h_m1 = '0;
        end else if ({1'b0, r_height} >= MAX_H_L) begin
            h_m1 = YW'(MAX_HEIGHT - 1);
        end else begin
            h_m1 = YW'(r_height - 1'b1);
        end
    end

    // Pipeline handshake: each stage loads when it is empty or drains
    assign rdy3    = !r_v3 || !i_stall;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign mv1     = r_v1 && rdy2;
    assign mv2     = r_v2 && rdy3;
    assign o_stall = !rdy1;
    assign acc     = i_valid && rdy1;

    // Position of the accepted item
    assign pos.odd_col   = r_x[0];
    assign pos.last_col  = (r_x == w_m1);
    assign pos.odd_row   = r_y[0];
    assign pos.last_row  = (r_y == h_m1);
    assign pos.frame_end = (r_x >= w_m1) && (r_y >= h_m1);

    // Advance the raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_x <= '0;
            r_y <= '0;
        end else if (acc) begin
            if (r_x >= w_m1) begin
                r_x <= '0;
                r_y <= (r_y >= h_m1) ? '0 : r_y + 1'b1;
            end else begin
                r_x <= r_x + 1'b1;
            end
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage 1: input register
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pix  <= i_pixel;
            r_s1_pos  <= pos;
            r_s1_slot <= AW'(r_x >> 1);
        end
    end

    b2i_csc u_csc (
        .i_pix  (r_s1_pix),
        .o_luma (csc_luma),
        .o_u    (csc_u),
        .o_v    (csc_v)
    );

    // Stage 2: converted samples
    always_ff @(posedge i_clk) begin
        if (mv1) begin
            r_s2_luma <= csc_luma;
            r_s2_u    <= csc_u;
            r_s2_v    <= csc_v;
            r_s2_pos  <= r_s1_pos;
            r_s2_slot <= r_s1_slot;
        end
    end

    b2i_line_store #(
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (line_we),
        .i_wr_addr (r_s2_slot),
        .i_wr_data (line_wd),
        .i_rd_en   (mv1),
        .i_rd_addr (r_s1_slot),
        .o_rd_data (line_rd)
    );

    b2i_chroma_avg u_chroma_avg (
        .i_pos     (r_s2_pos),
        .i_u       (r_s2_u),
        .i_v       (r_s2_v),
        .i_pair_u  (r_pair_u),
        .i_pair_v  (r_pair_v),
        .i_line    (line_rd),
        .o_pair_u  (n_pair_u),
        .o_pair_v  (n_pair_v),
        .o_wr_en   (line_we_raw),
        .o_wr_data (line_wd),
        .o_chroma  (chroma)
    );

    assign line_we = line_we_raw && mv2;

    // Hold the running pair sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_pair_u <= '0;
            r_pair_v <= '0;
        end else if (mv2) begin
            r_pair_u <= n_pair_u;
            r_pair_v <= n_pair_v;
        end
    end

    // Stage 3: output register
    always_ff @(posedge i_clk) begin
        if (mv2) begin
            r_out.luma         <= r_s2_luma;
            r_out.chroma_valid <= chroma.valid;
            r_out.u_sample     <= chroma.u;
            r_out.v_sample     <= chroma.v;
            r_out.frame_end    <= r_s2_pos.frame_end;
        end
    end

    assign o_valid = r_v3;
    assign o_pixel = r_out;

    // Position never leaves the frame
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_x <= w_m1) && (r_y <= h_m1))
        else $error("raster position outside frame");

    // A pair is either stored or completes a block, never both
    a_store_or_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> !(line_we_raw && chroma.valid))
        else $error("line store write on a completed block");

    // Input stalls only when every pipeline stage holds an item
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled with room in the pipeline");

    // A result item leaves stage 3 only after stage 2 held it
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v3) |-> $past(r_v2))
        else $error("output valid without a source item");

endmodule

FILE: design/b2i_csc.sv
module b2i_csc (
    input  b2i_pkg::t_pix_in i_pix,
    output logic [7:0]       o_luma,
    output logic [7:0]       o_u,
    output logic [7:0]       o_v
);
    import b2i_pkg::*;

    logic [SUM_W-1:0] b;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] y_sum;
    logic [SUM_W-1:0] u_sum;
    logic [SUM_W-1:0] v_sum;
    logic [8:0]       y_ofs;

    assign b = SUM_W'(i_pix.blue);
    assign g = SUM_W'(i_pix.green);
    assign r = SUM_W'(i_pix.red);

    // Weighted sums; chroma carries its bias so the difference stays positive
    assign y_sum = SUM_W'(Y_R) * r + SUM_W'(Y_G) * g + SUM_W'(Y_B) * b + SUM_W'(ROUND_OFS);
    assign u_sum = (SUM_W'(U_B) * b + SUM_W'(CHROMA_OFS)) - (SUM_W'(U_R) * r + SUM_W'(U_G) * g);
    assign v_sum = (SUM_W'(V_R) * r + SUM_W'(CHROMA_OFS)) - (SUM_W'(V_G) * g + SUM_W'(V_B) * b);

    // Scale down, add luma offset and saturate
    assign y_ofs  = {1'b0, y_sum[15:8]} + 9'(LUMA_OFS);
    assign o_luma = y_ofs[8] ? 8'hFF : y_ofs[7:0];
    assign o_u    = u_sum[15:8];
    assign o_v    = v_sum[15:8];

endmodule

FILE: design/b2i_chroma_avg.sv
module b2i_chroma_avg (
    input  b2i_pkg::t_pos                         i_pos,
    input  logic [7:0]                            i_u,
    input  logic [7:0]                            i_v,
    input  logic [b2i_pkg::PAIR_W-1:0]            i_pair_u,
    input  logic [b2i_pkg::PAIR_W-1:0]            i_pair_v,
    input  logic [b2i_pkg::ENTRY_W-1:0]           i_line,
    output logic [b2i_pkg::PAIR_W-1:0]            o_pair_u,
    output logic [b2i_pkg::PAIR_W-1:0]            o_pair_v,
    output logic                                  o_wr_en,
    output logic [b2i_pkg::ENTRY_W-1:0]           o_wr_data,
    output b2i_pkg::t_chroma                      o_chroma
);
    import b2i_pkg::*;

    logic                pair_done;
    logic                blk_valid;
    logic [PAIR_W:0]     sum_u;
    logic [PAIR_W:0]     sum_v;
    logic [PAIR_W:0]     avg_u;
    logic [PAIR_W:0]     avg_v;

    // Accumulate the horizontal pair
    assign o_pair_u = i_pos.odd_col ? i_pair_u + PAIR_W'(i_u) : PAIR_W'(i_u);
    assign o_pair_v = i_pos.odd_col ? i_pair_v + PAIR_W'(i_v) : PAIR_W'(i_v);

    // A pair closes on an odd column or at the right edge
    assign pair_done = i_pos.odd_col || i_pos.last_col;
    assign o_wr_en   = pair_done && !i_pos.odd_row && !i_pos.last_row;
    assign o_wr_data = {o_pair_v, o_pair_u};
    assign blk_valid = pair_done && (i_pos.odd_row || i_pos.last_row);

    // Add the pair from the row above on odd rows
    assign sum_u = i_pos.odd_row ? {1'b0, o_pair_u} + {1'b0, i_line[PAIR_W-1:0]}
                                 : {1'b0, o_pair_u};
    assign sum_v = i_pos.odd_row ? {1'b0, o_pair_v} + {1'b0, i_line[ENTRY_W-1:PAIR_W]}
                                 : {1'b0, o_pair_v};

    // Divide by the pixel count: four, two or one
    always_comb begin
        if (i_pos.odd_col && i_pos.odd_row) begin
            avg_u = sum_u >> 2;
            avg_v = sum_v >> 2;
        end else if (i_pos.odd_col || i_pos.odd_row) begin
            avg_u = sum_u >> 1;
            avg_v = sum_v >> 1;
        end else begin
            avg_u = sum_u;
            avg_v = sum_v;
        end
    end

    // Saturate and zero when no block completes
    always_comb begin
        o_chroma.valid = blk_valid;
        o_chroma.u     = '0;
        o_chroma.v     = '0;
        if (blk_valid) begin
            o_chroma.u = (avg_u > (PAIR_W+1)'(255)) ? 8'hFF : avg_u[7:0];
            o_chroma.v = (avg_v > (PAIR_W+1)'(255)) ? 8'hFF : avg_v[7:0];
        end
    end

endmodule

FILE: design/b2i_line_store.sv
module b2i_line_store #(
    parameter int DEPTH = 2048,
    parameter int AW = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [b2i_pkg::ENTRY_W-1:0]   i_wr_data,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [b2i_pkg::ENTRY_W-1:0]   o_rd_data
);
    import b2i_pkg::*;

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rd;
    logic [ENTRY_W-1:0] r_byp_data;
    logic               r_byp;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd       <= r_mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    // Forward a write that lands in the same cycle as the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_rd_en) begin
            r_byp <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rd;

endmodule
